@@ rtl/core/evad_pkg.sv @@
package evad_pkg;

  localparam int unsigned DATA_W     = 16;
  localparam int unsigned RAD_W      = 32;
  localparam int unsigned ROOT_STEPS = 16;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_LISTEN = 2'd1,
    MODE_SPEAK  = 2'd2,
    MODE_ENDED  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_THRESHOLD     = 2'd0,
    REG_MIN_SPEECH    = 2'd1,
    REG_SILENCE_LIMIT = 2'd2,
    REG_MAX_FRAMES    = 2'd3
  } cfg_idx_t;

  localparam logic [DATA_W-1:0] THRESHOLD_RST     = 16'd500;
  localparam logic [DATA_W-1:0] MIN_SPEECH_RST    = 16'd4;
  localparam logic [DATA_W-1:0] SILENCE_LIMIT_RST = 16'd40;
  localparam logic [DATA_W-1:0] MAX_FRAMES_RST    = 16'd320;

  typedef struct packed {
    logic [DATA_W-1:0] energy_thresh;
    logic [DATA_W-1:0] min_speech_frames;
    logic [DATA_W-1:0] silence_frames_limit;
    logic [DATA_W-1:0] max_frames;
  } cfg_t;

  typedef struct packed {
    mode_t             detector_mode;
    logic [DATA_W-1:0] frame_energy;
    logic              speech_flag;
    logic              stop_flag;
    logic [DATA_W-1:0] elapsed_frames;
    logic              frame_too_long;
  } result_t;

  function automatic logic [DATA_W-1:0] sat_inc(input logic [DATA_W-1:0] v);
    return (v == {DATA_W{1'b1}}) ? v : v + 16'd1;
  endfunction

endpackage

@@ rtl/core/evad_fifo.sv @@
module evad_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic [WIDTH-1:0]             wdata,
  input  logic                         pop,
  output logic [WIDTH-1:0]             rdata,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH-1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  assign rdata = mem_r[rd_ptr_r];
  assign empty = (count_r == '0);
  assign count = count_r;

endmodule

@@ rtl/core/evad_front.sv @@
module evad_front import evad_pkg::*; #(
  parameter int unsigned MAX_FRAME_SAMPLES = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                take,
  input  logic signed [DATA_W-1:0]            sample,
  input  logic                                last_in_frame,
  input  logic                                restart,
  output logic                                desc_valid,
  output logic [31+$clog2(MAX_FRAME_SAMPLES)-1:0] desc_sum,
  output logic [$clog2(MAX_FRAME_SAMPLES+1)-1:0]  desc_cnt,
  output logic                                desc_ovf,
  output logic                                desc_restart,
  output logic                                tail_last
);

  localparam int unsigned SUM_W = 31 + $clog2(MAX_FRAME_SAMPLES);
  localparam int unsigned CNT_W = $clog2(MAX_FRAME_SAMPLES+1);

  logic [DATA_W-1:0] raw;
  logic [DATA_W-1:0] mag;

  // square stage
  logic              a_valid_r;
  logic [RAD_W-1:0]  a_sq_r;
  logic              a_last_r;
  logic              a_restart_r;

  // accumulate stage
  logic [SUM_W-1:0]  sum_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              ovf_r;
  logic              pend_r;

  logic [SUM_W-1:0]  sum_base;
  logic [CNT_W-1:0]  cnt_base;
  logic              ovf_base;
  logic              pend_base;
  logic              room;
  logic [SUM_W-1:0]  sum_acc;
  logic [CNT_W-1:0]  cnt_acc;
  logic              ovf_acc;

  assign raw = sample;
  assign mag = raw[DATA_W-1] ? (~raw + 16'd1) : raw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      a_sq_r      <= {16'd0, mag} * {16'd0, mag};
      a_last_r    <= last_in_frame;
      a_restart_r <= restart;
    end
  end

  always_comb begin
    sum_base  = a_restart_r ? '0 : sum_r;
    cnt_base  = a_restart_r ? '0 : cnt_r;
    ovf_base  = a_restart_r ? 1'b0 : ovf_r;
    pend_base = a_restart_r | pend_r;
    room      = (cnt_base < CNT_W'(MAX_FRAME_SAMPLES));
    sum_acc   = room ? (sum_base + SUM_W'(a_sq_r)) : sum_base;
    cnt_acc   = room ? (cnt_base + 1'b1) : cnt_base;
    ovf_acc   = ovf_base | !room;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      cnt_r  <= '0;
      ovf_r  <= 1'b0;
      pend_r <= 1'b0;
    end else if (a_valid_r) begin
      if (a_last_r) begin
        sum_r  <= '0;
        cnt_r  <= '0;
        ovf_r  <= 1'b0;
        pend_r <= 1'b0;
      end else begin
        sum_r  <= sum_acc;
        cnt_r  <= cnt_acc;
        ovf_r  <= ovf_acc;
        pend_r <= pend_base;
      end
    end
  end

  assign desc_valid   = a_valid_r & a_last_r;
  assign desc_sum     = sum_acc;
  assign desc_cnt     = cnt_acc;
  assign desc_ovf     = ovf_acc;
  assign desc_restart = pend_base;
  assign tail_last    = a_valid_r & a_last_r;

endmodule

@@ rtl/core/evad_back.sv @@
module evad_back import evad_pkg::*; #(
  parameter int unsigned MAX_FRAME_SAMPLES = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cfg_t                 cfg,
  input  logic                 desc_empty,
  input  logic [31+$clog2(MAX_FRAME_SAMPLES)+$clog2(MAX_FRAME_SAMPLES+1)+2-1:0] desc_data,
  output logic                 desc_pop,
  input  logic                 res_pop,
  output logic                 res_valid,
  output result_t              res
);

  localparam int unsigned SUM_W  = 31 + $clog2(MAX_FRAME_SAMPLES);
  localparam int unsigned CNT_W  = $clog2(MAX_FRAME_SAMPLES+1);
  localparam int unsigned STEP_W = $clog2(SUM_W);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_ROOT, S_EVAL} state_t;

  state_t             state_r;
  logic [CNT_W-1:0]   rem_r;
  logic [SUM_W-1:0]   quo_r;
  logic [CNT_W-1:0]   den_r;
  logic [STEP_W-1:0]  step_r;
  logic [RAD_W-1:0]   rad_r;
  logic [RAD_W-1:0]   root_r;
  logic [RAD_W-1:0]   bit_r;
  logic               ovf_r;
  logic               rst_r;
  logic               zero_r;

  mode_t              mode_r;
  logic [DATA_W-1:0]  total_r;
  logic [DATA_W-1:0]  speech_cnt_r;
  logic [DATA_W-1:0]  silence_cnt_r;
  logic               res_valid_r;
  result_t            res_r;

  logic [SUM_W-1:0]   d_sum;
  logic [CNT_W-1:0]   d_cnt;
  logic               d_ovf;
  logic               d_restart;

  logic [CNT_W:0]     r2;
  logic [CNT_W:0]     diff;
  logic               ge;
  logic [CNT_W-1:0]   rem_nxt;
  logic [SUM_W-1:0]   quo_nxt;

  logic [RAD_W-1:0]   trial;
  logic               fit;
  logic [RAD_W-1:0]   rad_nxt;
  logic [RAD_W-1:0]   root_nxt;

  logic [DATA_W-1:0]  energy;
  logic               speech;
  mode_t              m;
  logic [DATA_W-1:0]  ft;
  logic [DATA_W-1:0]  sc;
  logic [DATA_W-1:0]  slc;
  logic               out_free;
  logic               res_load;

  assign {d_restart, d_ovf, d_cnt, d_sum} = desc_data;

  // restoring divide, one quotient bit per cycle
  always_comb begin
    r2      = {rem_r, quo_r[SUM_W-1]};
    ge      = (r2 >= {1'b0, den_r});
    diff    = r2 - {1'b0, den_r};
    rem_nxt = ge ? diff[CNT_W-1:0] : r2[CNT_W-1:0];
    quo_nxt = {quo_r[SUM_W-2:0], ge};
  end

  // digit-by-digit square root, two radicand bits per cycle
  always_comb begin
    trial    = root_r + bit_r;
    fit      = (rad_r >= trial);
    rad_nxt  = fit ? (rad_r - trial) : rad_r;
    root_nxt = fit ? ((root_r >> 1) + bit_r) : (root_r >> 1);
  end

  always_comb begin
    energy = zero_r ? '0 : root_r[DATA_W-1:0];
    speech = (energy > cfg.energy_thresh);
    m      = rst_r ? MODE_IDLE : mode_r;
    ft     = sat_inc(rst_r ? '0 : total_r);
    sc     = rst_r ? '0 : speech_cnt_r;
    slc    = rst_r ? '0 : silence_cnt_r;
    if (m == MODE_IDLE) begin
      m   = MODE_LISTEN;
      sc  = '0;
      slc = '0;
    end
    if (m == MODE_LISTEN) begin
      if (speech) begin
        sc = sat_inc(sc);
        if (sc >= cfg.min_speech_frames) begin
          m = MODE_SPEAK;
        end
      end
    end else if (m == MODE_SPEAK) begin
      if (speech) begin
        sc  = sat_inc(sc);
        slc = '0;
      end else begin
        slc = sat_inc(slc);
        if (slc >= cfg.silence_frames_limit) begin
          m = MODE_ENDED;
        end
      end
    end
    if (ft >= cfg.max_frames) begin
      m = MODE_ENDED;
    end
  end

  assign out_free = !res_valid_r || res_pop;
  assign res_load = (state_r == S_EVAL) && out_free;
  assign desc_pop = (state_r == S_IDLE) && !desc_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      mode_r        <= MODE_IDLE;
      total_r       <= '0;
      speech_cnt_r  <= '0;
      silence_cnt_r <= '0;
      res_valid_r   <= 1'b0;
    end else begin
      if (res_load || res_pop) begin
        res_valid_r <= res_load;
      end
      case (state_r)
        S_IDLE: begin
          if (!desc_empty) begin
            rem_r   <= '0;
            quo_r   <= d_sum;
            den_r   <= d_cnt;
            zero_r  <= (d_cnt == '0);
            ovf_r   <= d_ovf;
            rst_r   <= d_restart;
            step_r  <= STEP_W'(SUM_W-1);
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          rem_r  <= rem_nxt;
          quo_r  <= quo_nxt;
          step_r <= step_r - 1'b1;
          if (step_r == '0) begin
            rad_r   <= quo_nxt[RAD_W-1:0];
            root_r  <= '0;
            bit_r   <= {2'b01, {(RAD_W-2){1'b0}}};
            step_r  <= STEP_W'(ROOT_STEPS-1);
            state_r <= S_ROOT;
          end
        end
        S_ROOT: begin
          rad_r  <= rad_nxt;
          root_r <= root_nxt;
          bit_r  <= bit_r >> 2;
          step_r <= step_r - 1'b1;
          if (step_r == '0) begin
            state_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (out_free) begin
            mode_r               <= m;
            total_r              <= ft;
            speech_cnt_r         <= sc;
            silence_cnt_r        <= slc;
            res_r.detector_mode  <= m;
            res_r.frame_energy   <= energy;
            res_r.speech_flag    <= speech;
            res_r.stop_flag      <= (m == MODE_ENDED);
            res_r.elapsed_frames <= ft;
            res_r.frame_too_long <= ovf_r;
            state_r              <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

@@ rtl/core/energy_voice_activity_detector_unit.sv @@
// Energy voice activity detector.
// Input queue port: push one signed audio sample per transaction (in_push while in_full is
// low), with in_last_in_frame on the final sample of a frame and in_restart to clear the
// detector to idle and drop any partly gathered frame before that sample is taken.
// Result queue port: one result per closed frame; it stands on the out_ ports while
// out_empty is low and is taken with out_pop. Fields: detector mode, floor RMS energy,
// speech flag, stop flag, elapsed frame count and an overlong-frame flag.
// Configuration: write cfg_wdata into register cfg_index with cfg_we, only while idle.
// Throughput: one sample per cycle while frames are long enough to cover the frame-end
// math. Each closed frame passes the back end as a load, SUM_W divide steps (one
// quotient bit per cycle, SUM_W = 31 + clog2(MAX_FRAME_SAMPLES), 41 by default), 16 square
// root steps and an evaluation; a four-entry frame queue absorbs short bursts, and in_full
// rises when frames close faster than the back end drains them. The last sample of a frame
// passes the square register, the frame queue and the back end's load, divide, square root
// and evaluation states before its result appears, when back end and result register are free.
// Reset (synchronous, rst_n low): registers take their default limits, the detector is
// idle, both queues are empty. When the receiver stalls, the result is held, the back end
// waits and the frame queue fills; sample intake then stops through in_full.
module energy_voice_activity_detector_unit import evad_pkg::*; #(
  parameter int unsigned MAX_FRAME_SAMPLES = 1024
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_push,
  output logic                     in_full,
  input  logic signed [DATA_W-1:0] in_sample,
  input  logic                     in_last_in_frame,
  input  logic                     in_restart,
  output logic                     out_empty,
  input  logic                     out_pop,
  output logic [1:0]               out_detector_mode,
  output logic [DATA_W-1:0]        out_frame_energy,
  output logic                     out_speech_flag,
  output logic                     out_stop_flag,
  output logic [DATA_W-1:0]        out_elapsed_frames,
  output logic                     out_frame_too_long,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [DATA_W-1:0]        cfg_wdata
);

  localparam int unsigned SUM_W       = 31 + $clog2(MAX_FRAME_SAMPLES);
  localparam int unsigned CNT_W       = $clog2(MAX_FRAME_SAMPLES+1);
  localparam int unsigned DESC_W      = SUM_W + CNT_W + 2;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH+1);

  cfg_t              cfg_r;

  logic              take;
  logic              desc_valid;
  logic [SUM_W-1:0]  desc_sum;
  logic [CNT_W-1:0]  desc_cnt;
  logic              desc_ovf;
  logic              desc_restart;
  logic              tail_last;

  logic [DESC_W-1:0] q_wdata;
  logic [DESC_W-1:0] q_rdata;
  logic              q_empty;
  logic              q_pop;
  logic [QCNT_W-1:0] q_count;
  logic [QCNT_W:0]   q_need;

  logic              res_valid;
  logic              res_pop;
  result_t           res;

  // Configuration registers: hold defaults until software writes them.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.energy_thresh        <= THRESHOLD_RST;
      cfg_r.min_speech_frames    <= MIN_SPEECH_RST;
      cfg_r.silence_frames_limit <= SILENCE_LIMIT_RST;
      cfg_r.max_frames           <= MAX_FRAMES_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        REG_THRESHOLD:     cfg_r.energy_thresh        <= cfg_wdata;
        REG_MIN_SPEECH:    cfg_r.min_speech_frames    <= cfg_wdata;
        REG_SILENCE_LIMIT: cfg_r.silence_frames_limit <= cfg_wdata;
        REG_MAX_FRAMES:    cfg_r.max_frames           <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Back-pressure: the frame queue must keep a slot for a frame end still in the square
  // stage, so hold off intake once stored frames plus that one fill the queue.
  assign q_need  = {1'b0, q_count} + {{QCNT_W{1'b0}}, tail_last};
  assign in_full = (q_need >= (QCNT_W+1)'(QUEUE_DEPTH));
  assign take    = in_push && !in_full;

  // Front end: square each sample and sum the frame.
  evad_front #(
    .MAX_FRAME_SAMPLES (MAX_FRAME_SAMPLES)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .take          (take),
    .sample        (in_sample),
    .last_in_frame (in_last_in_frame),
    .restart       (in_restart),
    .desc_valid    (desc_valid),
    .desc_sum      (desc_sum),
    .desc_cnt      (desc_cnt),
    .desc_ovf      (desc_ovf),
    .desc_restart  (desc_restart),
    .tail_last     (tail_last)
  );

  // Closed frames wait here for the back end.
  assign q_wdata = {desc_restart, desc_ovf, desc_cnt, desc_sum};

  evad_fifo #(
    .WIDTH (DESC_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_frame_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (desc_valid),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty),
    .count (q_count)
  );

  // Back end: divide, square root, mode update, result register.
  assign res_pop = out_pop && res_valid;

  evad_back #(
    .MAX_FRAME_SAMPLES (MAX_FRAME_SAMPLES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .desc_empty (q_empty),
    .desc_data  (q_rdata),
    .desc_pop   (q_pop),
    .res_pop    (res_pop),
    .res_valid  (res_valid),
    .res        (res)
  );

  assign out_empty          = !res_valid;
  assign out_detector_mode  = res.detector_mode;
  assign out_frame_energy   = res.frame_energy;
  assign out_speech_flag    = res.speech_flag;
  assign out_stop_flag      = res.stop_flag;
  assign out_elapsed_frames = res.elapsed_frames;
  assign out_frame_too_long = res.frame_too_long;

endmodule

@@ rtl/core/evad_checker.sv @@
module evad_checker import evad_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_empty,
  input logic              out_pop,
  input logic [1:0]        out_detector_mode,
  input logic [DATA_W-1:0] out_frame_energy,
  input logic              out_stop_flag,
  input logic [DATA_W-1:0] out_elapsed_frames
);

  a_stop_matches_mode: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_stop_flag == (out_detector_mode == MODE_ENDED)))
    else $error("stop flag disagrees with detector mode");

  a_result_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_detector_mode != MODE_IDLE) && (out_frame_energy <= 16'd32768))
    else $error("result shows idle mode or energy out of range");

  a_frames_counted: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_elapsed_frames != '0))
    else $error("result with zero elapsed frames");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> !out_empty && $stable(out_frame_energy)
      && $stable(out_elapsed_frames) && $stable(out_detector_mode))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

endmodule

bind energy_voice_activity_detector_unit evad_checker u_evad_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_empty          (out_empty),
  .out_pop            (out_pop),
  .out_detector_mode  (out_detector_mode),
  .out_frame_energy   (out_frame_energy),
  .out_stop_flag      (out_stop_flag),
  .out_elapsed_frames (out_elapsed_frames)
);
